/* rtl/eepf_pkg.sv */
// shared types, sizes and register codes for the eroded extreme point finder
// no dependencies; imported by every module of the block
package eepf_pkg;

    // frame limits and derived widths
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int COORD_W    = 11;
    localparam int CFG_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int MIN_SIZE   = 3;

    // binarized level that marks a set pixel
    localparam logic [7:0] SET_LEVEL = 8'd255;

    // full 3x3 window
    localparam logic [8:0] WINDOW_FULL = 9'h1FF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    // reset sizes
    localparam logic [CFG_W-1:0] RESET_WIDTH  = 12'd640;
    localparam logic [CFG_W-1:0] RESET_HEIGHT = 12'd480;

    // event queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // result packing: found plus eight coordinates, padded to whole bytes
    localparam int RESULT_BITS = 1 + 8 * COORD_W;
    localparam int RESULT_W    = ((RESULT_BITS + 7) / 8) * 8;

    // one classified pixel handed from front to back
    typedef struct packed {
        logic             pix;
        logic             cand;
        logic             last;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } eepf_event_t;

    // the four corners
    typedef struct packed {
        logic [COORD_W-1:0] left_y;
        logic [COORD_W-1:0] left_x;
        logic [COORD_W-1:0] bottom_y;
        logic [COORD_W-1:0] bottom_x;
        logic [COORD_W-1:0] right_y;
        logic [COORD_W-1:0] right_x;
        logic [COORD_W-1:0] top_y;
        logic [COORD_W-1:0] top_x;
    } eepf_corners_t;

    // last index of a row or frame from a written size, clamped to [3, limit]
    function automatic logic [CFG_W-1:0] size_last(input logic [CFG_W-1:0] v,
                                                   input logic [CFG_W-1:0] limit);
        logic [CFG_W-1:0] s;
        if (v < CFG_W'(MIN_SIZE))
            s = CFG_W'(MIN_SIZE);
        else if (v > limit)
            s = limit;
        else
            s = v;
        return s - CFG_W'(1);
    endfunction

endpackage

/* rtl/eepf_front.sv */
// front end: size registers, raster counters, two-row line store and 3x3 window
// depends on eepf_pkg; classifies each pixel into an eepf_event_t
module eepf_front
    import eepf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 accept,
    input  logic [7:0]           pixel_value,
    output eepf_event_t          event_out
);

    localparam logic [CFG_W-1:0] WIDTH_LIMIT  = CFG_W'(MAX_WIDTH);
    localparam logic [CFG_W-1:0] HEIGHT_LIMIT = CFG_W'(MAX_HEIGHT);

    logic [COL_W-1:0] width_last_reg,  width_last_next;
    logic [ROW_W-1:0] height_last_reg, height_last_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [8:0]       window_reg, window_next;
    logic [1:0]       line_rd_reg;
    logic [1:0]       line_mem [MAX_WIDTH];

    logic             pix;
    logic             top_bit;
    logic             mid_bit;
    logic [2:0]       t3, m3, b3;
    logic             row_end;
    logic             frame_end;
    logic [CFG_W-1:0] w_last_full;
    logic [CFG_W-1:0] h_last_full;

    // clamped sizes, worked out when written
    assign w_last_full = size_last(cfg_data, WIDTH_LIMIT);
    assign h_last_full = size_last(cfg_data, HEIGHT_LIMIT);

    always_comb
    begin
        width_last_next  = width_last_reg;
        height_last_next = height_last_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  width_last_next  = w_last_full[COL_W-1:0];
                REG_FRAME_HEIGHT: height_last_next = h_last_full[ROW_W-1:0];
                default:          ;
            endcase
        end
    end

    // window shift: new column enters at bit 0 of each row of three
    assign pix     = (pixel_value == SET_LEVEL);
    assign top_bit = line_rd_reg[1];
    assign mid_bit = line_rd_reg[0];
    assign t3 = {window_reg[1:0], top_bit};
    assign m3 = {window_reg[4:3], mid_bit};
    assign b3 = {window_reg[7:6], pix};

    // raster position
    assign row_end   = (col_reg >= width_last_reg);
    assign frame_end = row_end && (row_reg >= height_last_reg);

    always_comb
    begin
        window_next = window_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        if (accept)
        begin
            window_next = {b3, m3, t3};
            if (frame_end)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (row_end)
            begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    // classified event for the back end
    always_comb
    begin
        event_out.pix  = pix;
        event_out.cand = (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2))
                         && ({b3, m3, t3} == WINDOW_FULL);
        event_out.last = frame_end;
        event_out.col  = col_reg;
        event_out.row  = row_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_last_reg  <= COL_W'(RESET_WIDTH - CFG_W'(1));
            height_last_reg <= ROW_W'(RESET_HEIGHT - CFG_W'(1));
            col_reg         <= '0;
            row_reg         <= '0;
            window_reg      <= '0;
        end
        else
        begin
            width_last_reg  <= width_last_next;
            height_last_reg <= height_last_next;
            col_reg         <= col_next;
            row_reg         <= row_next;
            window_reg      <= window_next;
        end
    end

    // line store: write this column, fetch the next column ahead of time
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            line_mem[col_reg] <= {mid_bit, pix};
            line_rd_reg       <= line_mem[col_next];
        end
    end

endmodule

/* rtl/eepf_queue.sv */
// short event queue between the front and back ends
// depends on eepf_pkg for the event type and depth
module eepf_queue
    import eepf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  eepf_event_t push_data,
    input  logic        pop,
    output eepf_event_t pop_data,
    output logic        full,
    output logic        empty
);

    eepf_event_t            slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QUEUE_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QUEUE_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + QUEUE_CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QUEUE_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

/* rtl/eepf_back.sv */
// back end: corner tracking and the per-frame result register
// depends on eepf_pkg; drains events from eepf_queue
module eepf_back
    import eepf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  eepf_event_t         q_data,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [RESULT_W-1:0] m_tdata
);

    logic                seen_reg, seen_next;
    eepf_corners_t       corners_reg, corners_next;
    logic                out_valid_reg, out_valid_next;
    logic [RESULT_W-1:0] out_data_reg, out_data_next;

    logic                out_free;
    logic                upd_seen;
    eepf_corners_t       upd;
    logic [COORD_W-1:0]  ev_x, ev_y, cx, cy;

    assign out_free = !out_valid_reg || m_tready;
    assign q_pop    = !q_empty && (!q_data.last || out_free);

    assign ev_x = COORD_W'(q_data.col);
    assign ev_y = COORD_W'(q_data.row);
    // window centre sits one row up and one column left
    assign cx   = ev_x - COORD_W'(1);
    assign cy   = ev_y - COORD_W'(1);

    // corner update, then result load and frame clear on the last pixel
    always_comb
    begin
        upd_seen       = seen_reg;
        upd            = corners_reg;
        seen_next      = seen_reg;
        corners_next   = corners_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (q_pop)
        begin
            if (q_data.pix && !seen_reg)
            begin
                upd_seen     = 1'b1;
                upd.top_x    = ev_x;
                upd.top_y    = ev_y;
                upd.right_x  = ev_x;
                upd.right_y  = ev_y;
                upd.bottom_x = ev_x;
                upd.bottom_y = ev_y;
                upd.left_x   = ev_x;
                upd.left_y   = ev_y;
            end
            else if (q_data.cand)
            begin
                if (corners_reg.top_y > cy)
                begin
                    upd.top_x = cx;
                    upd.top_y = cy;
                end
                if (corners_reg.right_x < cx)
                begin
                    upd.right_x = cx;
                    upd.right_y = cy;
                end
                if (corners_reg.bottom_y < cy)
                begin
                    upd.bottom_x = cx;
                    upd.bottom_y = cy;
                end
                if (corners_reg.left_x > cx)
                begin
                    upd.left_x = cx;
                    upd.left_y = cy;
                end
            end
            seen_next    = upd_seen;
            corners_next = upd;
            if (q_data.last)
            begin
                out_valid_next = 1'b1;
                out_data_next  = RESULT_W'({upd, upd_seen});
                seen_next      = 1'b0;
                corners_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= 1'b0;
            corners_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seen_reg      <= seen_next;
            corners_reg   <= corners_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

/* rtl/eroded_extreme_point_finder.sv */
// top level of the eroded extreme point finder
// depends on eepf_pkg, eepf_front, eepf_queue and eepf_back

// Takes a binarized frame in raster order, one pixel per transfer (255 means
// set), and returns one result per frame on the transfer after its last pixel
// has been processed: a found flag and the top, right, bottom and left corners
// of the set region, where after the first set pixel only pixels whose whole
// 3x3 neighbourhood is set move a corner. Pixels are taken at one per clock
// while the event queue is not full; the rate is set by the line store, read
// one column ahead and written once per pixel, one read and one write each
// cycle. The result is registered after the last pixel's event leaves the
// queue, unless the previous result is still waiting. A four-entry event queue
// between the classifier and the corner tracker absorbs short result-side stalls.
// Frame width and height (index 0 and 1) are to be written by the user through
// the cfg port only between frames; the block does not enforce this. Values
// are clamped to 3 to 2048. The line store needs no clearing after reset.
module eroded_extreme_point_finder
    import eepf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    // pixel stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] pixel_value
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [RESULT_W-1:0]  m_tdata    // [0] found, then 11 bits each:
                                            // top_x, top_y, right_x, right_y,
                                            // bottom_x, bottom_y, left_x, left_y,
                                            // zero padding above
);

    eepf_event_t front_event;
    eepf_event_t q_data;
    logic        accept;
    logic        q_full;
    logic        q_empty;
    logic        q_pop;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;

    // pixel classification
    eepf_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .accept      (accept),
        .pixel_value (s_tdata),
        .event_out   (front_event)
    );

    // decoupling queue
    eepf_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (front_event),
        .pop       (q_pop),
        .pop_data  (q_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    // corner tracking and result
    eepf_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`ifndef SYNTHESIS
    // queue cannot be full and empty at once
    assert property (@(posedge clk) disable iff (!rst_n) !(q_full && q_empty))
        else $error("event queue full and empty together");

    // a frame with no set pixel reports all corners as zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[RESULT_BITS-1:1] == '0)
        else $error("corners not cleared for an empty frame");

    // top never below bottom, left never right of right
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> (m_tdata[22:12] <= m_tdata[66:56])
                                   && (m_tdata[77:67] <= m_tdata[33:23]))
        else $error("corner order broken");
`endif

endmodule
